[rtl/deu_pkg.sv]
// Shared types, constants and helpers of the digitizer event word unpacker.
package deu_pkg;

    // Number of groups the digitizer can carry in one event.
    localparam int NUM_GROUPS = 4;
    // Largest sample count that a group header may announce.
    localparam int MAX_SAMPLES = 1024;
    // Depth of the queue between the parser and the result sequencer.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

    // Header marker expected in bits 31..28 of header word 0.
    localparam logic [3:0] HEADER_MARKER = 4'ha;
    // Mask bits that belong to groups which can exist.
    localparam logic [3:0] GROUP_BITS = 4'((1 << NUM_GROUPS) - 1);
    // Reciprocal of three, scaled by 2**13, exact for 12-bit operands.
    localparam logic [11:0] RECIP3 = 12'd2731;

    // Result kinds.
    typedef enum logic [2:0] {
        KIND_CHAN_SAMPLE = 3'd0,
        KIND_TRIG_SAMPLE = 3'd1,
        KIND_GROUP_HDR   = 3'd2,
        KIND_FORMAT_ERR  = 3'd3,
        KIND_EVENT_HDR   = 3'd4,
        KIND_EVENT_END   = 3'd5
    } kind_t;

    // Parser phases.
    typedef enum logic [2:0] {
        PH_WAIT  = 3'd0,
        PH_MASK  = 3'd1,
        PH_EVNR  = 3'd2,
        PH_SKIP  = 3'd3,
        PH_GHDR  = 3'd4,
        PH_CHAN  = 3'd5,
        PH_TRIG  = 3'd6,
        PH_TRAIL = 3'd7
    } phase_t;

    // One result slot of a parsed word.
    typedef struct packed {
        logic [2:0]  channel;
        logic [9:0]  sample_index;
        logic [11:0] value;
    } deu_slot_t;

    // Everything the back end needs to emit the results of one word.
    typedef struct packed {
        kind_t            kind;
        logic [1:0]       group;
        logic             trigger_present;
        logic [21:0]      event_number;
        logic [27:0]      payload_length;
        logic [3:0]       enabled_groups;
        logic [1:0]       frequency;
        logic [9:0]       start_cell;
        logic [1:0]       count;
        deu_slot_t [2:0]  slots;
    } deu_entry_t;

    // Queue status seen by both ends.
    typedef struct packed {
        logic full;
        logic empty;
    } deu_queue_status_t;

    // First present group at or above 'from'; NUM_GROUPS when there is none.
    function automatic logic [2:0] next_group(logic [3:0] mask, logic [2:0] from);
        logic [2:0] g;
        g = 3'(NUM_GROUPS);
        for (int i = NUM_GROUPS - 1; i >= 0; i--)
        begin
            if ((i >= int'(from)) && mask[i])
            begin
                g = 3'(i);
            end
        end
        return g;
    endfunction

endpackage

[rtl/digitizer_event_word_unpacker.sv]
// Digitizer event word unpacker.
// The input channel (in_valid, in_ready, word, start_of_event) takes one
// 32-bit word of a digitizer event per transfer. The output channel
// (out_valid, out_ready and the result fields) delivers zero to three
// results per word: event header, group headers, unpacked 12-bit channel
// and trigger samples, event end and format errors; 'last' marks the final
// result of a word.
// A word is accepted in any cycle in which the four-entry queue between
// the parser and the result sequencer has room, so words flow at one per
// cycle while the output keeps pace. When the queue is empty, the first
// result of a word passes through its queue entry and then the output
// register before it is presented. The output side issues one result per
// cycle while out_ready is high, so a word that yields three results needs
// three transfers; that single output register sets the sustained rate.
// When the receiver stalls, the queue fills and in_ready drops once it is
// full. Reset clears the parser to wait for an event header, empties the
// queue and drops out_valid.
module digitizer_event_word_unpacker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] word,
    input  logic        start_of_event,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  kind,
    output logic [1:0]  group,
    output logic [2:0]  channel,
    output logic [9:0]  sample_index,
    output logic [11:0] value,
    output logic [21:0] event_number,
    output logic [27:0] payload_length,
    output logic [3:0]  enabled_groups,
    output logic [1:0]  frequency,
    output logic [9:0]  start_cell,
    output logic        trigger_present,
    output logic        last
);

    deu_pkg::deu_queue_status_t q_status;
    deu_pkg::deu_entry_t        push_entry;
    deu_pkg::deu_entry_t        head;
    logic                       push;
    logic                       pop;

    // Parser.
    deu_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .word           (word),
        .start_of_event (start_of_event),
        .q_status       (q_status),
        .push           (push),
        .entry          (push_entry)
    );

    // Queue between parser and sequencer.
    deu_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .status     (q_status)
    );

    // Result sequencer.
    deu_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .head            (head),
        .q_status        (q_status),
        .pop             (pop),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .kind            (kind),
        .group           (group),
        .channel         (channel),
        .sample_index    (sample_index),
        .value           (value),
        .event_number    (event_number),
        .payload_length  (payload_length),
        .enabled_groups  (enabled_groups),
        .frequency       (frequency),
        .start_cell      (start_cell),
        .trigger_present (trigger_present),
        .last            (last)
    );

endmodule

[rtl/deu_front.sv]
// Front end: accepts stream words, tracks the event structure and turns
// each word that causes results into one queue entry describing them.
module deu_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [31:0]                word,
    input  logic                       start_of_event,
    input  deu_pkg::deu_queue_status_t q_status,
    output logic                       push,
    output deu_pkg::deu_entry_t        entry
);

    deu_pkg::phase_t phase_reg, phase_next;
    logic [27:0] length_reg, length_next;
    logic [3:0]  mask_reg, mask_next;
    logic [1:0]  group_reg, group_next;
    logic [10:0] count_reg, count_next;
    logic        known_reg, known_next;
    logic [10:0] cursor_reg, cursor_next;
    logic [1:0]  trip_reg, trip_next;
    logic [7:0]  carry_reg, carry_next;
    logic        trig_reg, trig_next;
    logic [1:0]  freq_reg, freq_next;
    logic [21:0] event_reg, event_next;

    logic        accept;
    logic [11:0] vals [3];
    logic [7:0]  carry_unpack;
    logic [1:0]  nvals;
    logic [2:0]  base;
    logic [23:0] div_prod;
    logic [10:0] hdr_count;
    logic [10:0] count_eff;
    logic [2:0]  grp_first;
    logic [2:0]  grp_after;
    logic [11:0] trig_k [3];
    logic [10:0] cursor_inc1;
    logic [10:0] cursor_inc8;

    assign in_ready = !q_status.full;
    assign accept   = in_valid && in_ready;

    // Unpack the 12-bit values carried by this word of a triplet.
    always_comb
    begin
        carry_unpack = carry_reg;
        vals[2]      = '0;
        unique case (trip_reg)
            2'd0:
            begin
                vals[0]      = word[11:0];
                vals[1]      = word[23:12];
                carry_unpack = word[31:24];
                nvals        = 2'd2;
                base         = 3'd0;
            end
            2'd1:
            begin
                vals[0]      = {word[3:0], carry_reg};
                vals[1]      = word[15:4];
                vals[2]      = word[27:16];
                carry_unpack = {4'd0, word[31:28]};
                nvals        = 2'd3;
                base         = 3'd2;
            end
            default:
            begin
                vals[0] = {word[7:0], carry_reg[3:0]};
                vals[1] = word[19:8];
                vals[2] = word[31:20];
                nvals   = 2'd3;
                base    = 3'd5;
            end
        endcase
    end

    // Sample count from the header word count, divided by three and clamped.
    assign div_prod  = {12'd0, word[11:0]} * {12'd0, deu_pkg::RECIP3};
    assign hdr_count = (div_prod[23:13] > 11'(deu_pkg::MAX_SAMPLES))
                     ? 11'(deu_pkg::MAX_SAMPLES) : div_prod[23:13];
    assign count_eff = known_reg ? count_reg : hdr_count;

    assign grp_first = deu_pkg::next_group(mask_reg, 3'd0);
    assign grp_after = deu_pkg::next_group(mask_reg, {1'b0, group_reg} + 3'd1);

    assign cursor_inc1 = cursor_reg + 11'd1;
    assign cursor_inc8 = cursor_reg + 11'd8;

    // Trigger sample positions of the slots in this word.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            trig_k[i] = {1'b0, cursor_reg} + 12'(base) + 12'(i);
        end
    end

    // Next state of the parser.
    always_comb
    begin
        phase_next  = phase_reg;
        length_next = length_reg;
        mask_next   = mask_reg;
        group_next  = group_reg;
        count_next  = count_reg;
        known_next  = known_reg;
        cursor_next = cursor_reg;
        trip_next   = trip_reg;
        carry_next  = carry_reg;
        trig_next   = trig_reg;
        freq_next   = freq_reg;
        event_next  = event_reg;
        if (start_of_event || phase_reg == deu_pkg::PH_WAIT)
        begin
            phase_next  = deu_pkg::PH_WAIT;
            length_next = '0;
            mask_next   = '0;
            group_next  = '0;
            count_next  = '0;
            known_next  = 1'b0;
            cursor_next = '0;
            trip_next   = '0;
            carry_next  = '0;
            trig_next   = 1'b0;
            freq_next   = '0;
            event_next  = '0;
            if (word[31:28] == deu_pkg::HEADER_MARKER)
            begin
                length_next = word[27:0];
                phase_next  = deu_pkg::PH_MASK;
            end
        end
        else
        begin
            unique case (phase_reg)
                deu_pkg::PH_MASK:
                begin
                    mask_next  = word[3:0] & deu_pkg::GROUP_BITS;
                    phase_next = deu_pkg::PH_EVNR;
                end
                deu_pkg::PH_EVNR:
                begin
                    event_next = word[21:0];
                    phase_next = deu_pkg::PH_SKIP;
                end
                deu_pkg::PH_SKIP:
                begin
                    if (grp_first == 3'(deu_pkg::NUM_GROUPS))
                    begin
                        phase_next = deu_pkg::PH_WAIT;
                    end
                    else
                    begin
                        group_next = grp_first[1:0];
                        phase_next = deu_pkg::PH_GHDR;
                    end
                end
                deu_pkg::PH_GHDR:
                begin
                    trig_next = word[12];
                    if (!known_reg)
                    begin
                        count_next = hdr_count;
                        freq_next  = word[17:16];
                        known_next = 1'b1;
                    end
                    cursor_next = '0;
                    trip_next   = '0;
                    carry_next  = '0;
                    phase_next  = (count_eff != 11'd0) ? deu_pkg::PH_CHAN
                                                       : deu_pkg::PH_TRAIL;
                end
                deu_pkg::PH_CHAN:
                begin
                    carry_next = carry_unpack;
                    if (trip_reg == 2'd0 || trip_reg == 2'd1)
                    begin
                        trip_next = trip_reg + 2'd1;
                    end
                    else
                    begin
                        trip_next   = '0;
                        cursor_next = cursor_inc1;
                        if (cursor_inc1 >= count_reg)
                        begin
                            cursor_next = '0;
                            phase_next  = trig_reg ? deu_pkg::PH_TRIG
                                                   : deu_pkg::PH_TRAIL;
                        end
                    end
                end
                deu_pkg::PH_TRIG:
                begin
                    carry_next = carry_unpack;
                    if (trip_reg == 2'd0 || trip_reg == 2'd1)
                    begin
                        trip_next = trip_reg + 2'd1;
                    end
                    else
                    begin
                        trip_next   = '0;
                        cursor_next = cursor_inc8;
                        if (cursor_inc8 >= count_reg)
                        begin
                            cursor_next = '0;
                            phase_next  = deu_pkg::PH_TRAIL;
                        end
                    end
                end
                deu_pkg::PH_TRAIL:
                begin
                    if (grp_after == 3'(deu_pkg::NUM_GROUPS))
                    begin
                        phase_next = deu_pkg::PH_WAIT;
                    end
                    else
                    begin
                        group_next = grp_after[1:0];
                        phase_next = deu_pkg::PH_GHDR;
                    end
                end
                default:
                begin
                    phase_next = deu_pkg::PH_WAIT;
                end
            endcase
        end
    end

    // Queue entry for this word: kind, result count and the slot contents.
    always_comb
    begin
        entry.kind       = deu_pkg::KIND_EVENT_END;
        entry.count      = 2'd0;
        entry.start_cell = '0;
        for (int i = 0; i < 3; i++)
        begin
            entry.slots[i].channel      = '0;
            entry.slots[i].sample_index = '0;
            entry.slots[i].value        = '0;
        end
        if (start_of_event || phase_reg == deu_pkg::PH_WAIT)
        begin
            entry.kind  = deu_pkg::KIND_FORMAT_ERR;
            entry.count = (word[31:28] == deu_pkg::HEADER_MARKER) ? 2'd0 : 2'd1;
        end
        else
        begin
            unique case (phase_reg)
                deu_pkg::PH_EVNR:
                begin
                    entry.kind  = deu_pkg::KIND_EVENT_HDR;
                    entry.count = 2'd1;
                end
                deu_pkg::PH_SKIP:
                begin
                    entry.kind  = deu_pkg::KIND_EVENT_END;
                    entry.count = (grp_first == 3'(deu_pkg::NUM_GROUPS)) ? 2'd1 : 2'd0;
                end
                deu_pkg::PH_TRAIL:
                begin
                    entry.kind  = deu_pkg::KIND_EVENT_END;
                    entry.count = (grp_after == 3'(deu_pkg::NUM_GROUPS)) ? 2'd1 : 2'd0;
                end
                deu_pkg::PH_GHDR:
                begin
                    entry.kind       = deu_pkg::KIND_GROUP_HDR;
                    entry.count      = 2'd1;
                    entry.start_cell = word[29:20];
                end
                deu_pkg::PH_CHAN:
                begin
                    entry.kind  = deu_pkg::KIND_CHAN_SAMPLE;
                    entry.count = nvals;
                    for (int i = 0; i < 3; i++)
                    begin
                        entry.slots[i].channel      = base + 3'(i);
                        entry.slots[i].sample_index = cursor_reg[9:0];
                        entry.slots[i].value        = vals[i];
                    end
                end
                deu_pkg::PH_TRIG:
                begin
                    // Slots beyond the sample count are always at the tail.
                    entry.kind  = deu_pkg::KIND_TRIG_SAMPLE;
                    entry.count = 2'({1'b0, (trig_k[0] < {1'b0, count_reg})}
                                   + {1'b0, (trig_k[1] < {1'b0, count_reg})}
                                   + {1'b0, (nvals == 2'd3)
                                            && (trig_k[2] < {1'b0, count_reg})});
                    for (int i = 0; i < 3; i++)
                    begin
                        entry.slots[i].sample_index = trig_k[i][9:0];
                        entry.slots[i].value        = vals[i];
                    end
                end
                default:
                begin
                    entry.count = 2'd0;
                end
            endcase
        end
        // Event values are those in force once this word has been taken.
        entry.event_number    = event_next;
        entry.payload_length  = length_next;
        entry.enabled_groups  = mask_next;
        entry.frequency       = freq_next;
        entry.group           = (entry.kind == deu_pkg::KIND_CHAN_SAMPLE
                                 || entry.kind == deu_pkg::KIND_TRIG_SAMPLE
                                 || entry.kind == deu_pkg::KIND_GROUP_HDR)
                              ? group_next : 2'd0;
        entry.trigger_present = (entry.kind == deu_pkg::KIND_CHAN_SAMPLE
                                 || entry.kind == deu_pkg::KIND_TRIG_SAMPLE
                                 || entry.kind == deu_pkg::KIND_GROUP_HDR)
                              ? trig_next : 1'b0;
    end

    assign push = accept && (entry.count != 2'd0);

    // Parser state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= deu_pkg::PH_WAIT;
            length_reg <= '0;
            mask_reg   <= '0;
            group_reg  <= '0;
            count_reg  <= '0;
            known_reg  <= 1'b0;
            cursor_reg <= '0;
            trip_reg   <= '0;
            carry_reg  <= '0;
            trig_reg   <= 1'b0;
            freq_reg   <= '0;
            event_reg  <= '0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            length_reg <= length_next;
            mask_reg   <= mask_next;
            group_reg  <= group_next;
            count_reg  <= count_next;
            known_reg  <= known_next;
            cursor_reg <= cursor_next;
            trip_reg   <= trip_next;
            carry_reg  <= carry_next;
            trig_reg   <= trig_next;
            freq_reg   <= freq_next;
            event_reg  <= event_next;
        end
    end

endmodule

[rtl/deu_queue.sv]
// Short first-in first-out queue of parsed word entries.
module deu_queue (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  deu_pkg::deu_entry_t        push_entry,
    input  logic                       pop,
    output deu_pkg::deu_entry_t        head,
    output deu_pkg::deu_queue_status_t status
);

    deu_pkg::deu_entry_t store [deu_pkg::QUEUE_DEPTH];
    logic [deu_pkg::QUEUE_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [deu_pkg::QUEUE_AW:0]   fill_reg, fill_next;

    assign status.full  = (fill_reg == (deu_pkg::QUEUE_AW+1)'(deu_pkg::QUEUE_DEPTH));
    assign status.empty = (fill_reg == '0);
    assign head         = store[rd_ptr_reg];

    // Fill level follows the pushes and pops of each cycle.
    always_comb
    begin
        fill_next = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (deu_pkg::QUEUE_AW)'((32'(wr_ptr_reg) + 1)
                                                   % deu_pkg::QUEUE_DEPTH);
            end
            if (pop)
            begin
                rd_ptr_reg <= (deu_pkg::QUEUE_AW)'((32'(rd_ptr_reg) + 1)
                                                   % deu_pkg::QUEUE_DEPTH);
            end
            fill_reg <= fill_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

[rtl/deu_back.sv]
// Back end: walks the slots of the head entry and presents one result per
// transfer from an output register.
module deu_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  deu_pkg::deu_entry_t        head,
    input  deu_pkg::deu_queue_status_t q_status,
    output logic                       pop,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [2:0]                 kind,
    output logic [1:0]                 group,
    output logic [2:0]                 channel,
    output logic [9:0]                 sample_index,
    output logic [11:0]                value,
    output logic [21:0]                event_number,
    output logic [27:0]                payload_length,
    output logic [3:0]                 enabled_groups,
    output logic [1:0]                 frequency,
    output logic [9:0]                 start_cell,
    output logic                       trigger_present,
    output logic                       last
);

    logic        valid_reg, valid_next;
    logic [1:0]  slot_reg, slot_next;
    logic        load;
    logic        slot_last;
    deu_pkg::deu_slot_t cur_slot;

    logic [2:0]  kind_reg;
    logic [1:0]  group_reg;
    logic [2:0]  channel_reg;
    logic [9:0]  index_reg;
    logic [11:0] value_reg;
    logic [21:0] event_reg;
    logic [27:0] length_reg;
    logic [3:0]  mask_reg;
    logic [1:0]  freq_reg;
    logic [9:0]  icell_reg;
    logic        trig_reg;
    logic        last_reg;

    // A new result is loaded whenever the queue holds an entry and the output register is free or drains.
    assign load      = !q_status.empty && (!valid_reg || out_ready);
    assign slot_last = (slot_reg == head.count - 2'd1);
    assign pop       = load && slot_last;
    assign cur_slot  = head.slots[slot_reg];

    always_comb
    begin
        slot_next  = slot_reg;
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
            slot_next  = slot_last ? 2'd0 : slot_reg + 2'd1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    // Handshake state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            slot_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            slot_reg  <= slot_next;
        end
    end

    // Result payload register.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg    <= head.kind;
            group_reg   <= head.group;
            channel_reg <= cur_slot.channel;
            index_reg   <= cur_slot.sample_index;
            value_reg   <= cur_slot.value;
            event_reg   <= head.event_number;
            length_reg  <= head.payload_length;
            mask_reg    <= head.enabled_groups;
            freq_reg    <= head.frequency;
            icell_reg   <= head.start_cell;
            trig_reg    <= head.trigger_present;
            last_reg    <= slot_last;
        end
    end

    assign out_valid       = valid_reg;
    assign kind            = kind_reg;
    assign group           = group_reg;
    assign channel         = channel_reg;
    assign sample_index    = index_reg;
    assign value           = value_reg;
    assign event_number    = event_reg;
    assign payload_length  = length_reg;
    assign enabled_groups  = mask_reg;
    assign frequency       = freq_reg;
    assign start_cell      = icell_reg;
    assign trigger_present = trig_reg;
    assign last            = last_reg;

endmodule

[tb/testbench.sv]
module testbench;

    // Cycles without any transfer before the run is declared hung.
    localparam int IDLE_LIMIT = 1000;

    // One word waiting to be offered to the block.
    typedef struct {
        logic [31:0] data;
        logic        sof;
        logic        drain_first;
    } stream_word_t;

    // One result as the unpacker should deliver it.
    typedef struct {
        deu_pkg::kind_t kind;
        logic [1:0]     grp;
        logic [2:0]     chan;
        logic [9:0]     sidx;
        logic [11:0]    val;
        logic [21:0]    evnum;
        logic [27:0]    plen;
        logic [3:0]     gmask;
        logic [1:0]     freq;
        logic [9:0]     icell;
        logic           trig;
        logic           last;
    } unpacked_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [31:0] word = 32'h0;
    logic        start_of_event = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  kind;
    logic [1:0]  group;
    logic [2:0]  channel;
    logic [9:0]  sample_index;
    logic [11:0] value;
    logic [21:0] event_number;
    logic [27:0] payload_length;
    logic [3:0]  enabled_groups;
    logic [1:0]  frequency;
    logic [9:0]  start_cell;
    logic        trigger_present;
    logic        last;

    stream_word_t     word_stream [$];
    unpacked_result_t predicted_results [$];

    logic word_taken = 1'b0;
    int   words_queued = 0;
    int   words_accepted = 0;
    int   cycle_count = 0;
    int   idle_cycles = 0;
    int   fail_count = 0;
    int   hold_left = 0;
    int   holds_done = 0;
    logic calm;

    // Mirror of the parser state.
    deu_pkg::phase_t prs_phase;
    logic [27:0] ev_length;
    logic [3:0]  ev_mask;
    logic [1:0]  cur_group;
    logic [10:0] n_samples;
    logic        n_known;
    logic [10:0] samp_pos;
    logic [1:0]  word_in_triplet;
    logic [7:0]  held_bits;
    logic        grp_trigger;
    logic [1:0]  ev_freq;
    logic [21:0] ev_number;

    digitizer_event_word_unpacker u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .word            (word),
        .start_of_event  (start_of_event),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .kind            (kind),
        .group           (group),
        .channel         (channel),
        .sample_index    (sample_index),
        .value           (value),
        .event_number    (event_number),
        .payload_length  (payload_length),
        .enabled_groups  (enabled_groups),
        .frequency       (frequency),
        .start_cell      (start_cell),
        .trigger_present (trigger_present),
        .last            (last)
    );

    // Clock with a period of ten units.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // A stretch in the middle of the run in which neither side idles.
    assign calm = (cycle_count >= 200) && (cycle_count < 400);

    // Return the lowest present group at or above 'from', or NUM_GROUPS.
    function automatic int first_group(input logic [3:0] mask, input int from);
        for (int g = from; g < deu_pkg::NUM_GROUPS; g++)
        begin
            if (mask[g])
            begin
                return g;
            end
        end
        return deu_pkg::NUM_GROUPS;
    endfunction

    // Return the parser mirror to its idle state.
    task automatic clear_parser();
        prs_phase       = deu_pkg::PH_WAIT;
        ev_length       = '0;
        ev_mask         = '0;
        cur_group       = '0;
        n_samples       = '0;
        n_known         = 1'b0;
        samp_pos        = '0;
        word_in_triplet = '0;
        held_bits       = '0;
        grp_trigger     = 1'b0;
        ev_freq         = '0;
        ev_number       = '0;
    endtask

    // Append one predicted result built from the latched event state.
    task automatic add_result(input deu_pkg::kind_t k, input logic [2:0] ch,
                              input logic [9:0] idx, input logic [11:0] val,
                              input logic [9:0] icell_val);
        unpacked_result_t r;
        r.kind  = k;
        r.grp   = (k <= deu_pkg::KIND_GROUP_HDR) ? cur_group : 2'd0;
        r.chan  = ch;
        r.sidx  = idx;
        r.val   = val;
        r.evnum = ev_number;
        r.plen  = ev_length;
        r.gmask = ev_mask;
        r.freq  = ev_freq;
        r.icell = icell_val;
        r.trig  = (k <= deu_pkg::KIND_GROUP_HDR) ? grp_trigger : 1'b0;
        r.last  = 1'b0;
        predicted_results.push_back(r);
    endtask

    // Work out the results that one accepted word causes.
    task automatic decode_word(input logic [31:0] w, input logic sof);
        int          n_before;
        int          g;
        int          cnt;
        int          base;
        int          k;
        logic [11:0] v [3];
        n_before = predicted_results.size();
        cnt = 0;
        base = 0;
        if (sof || prs_phase == deu_pkg::PH_WAIT)
        begin
            clear_parser();
            if (w[31:28] != deu_pkg::HEADER_MARKER)
            begin
                add_result(deu_pkg::KIND_FORMAT_ERR, 3'd0, 10'd0, 12'd0, 10'd0);
            end
            else
            begin
                ev_length = w[27:0];
                prs_phase = deu_pkg::PH_MASK;
            end
        end
        else
        begin
            // Sample words of a triplet carry two or three packed values.
            if (prs_phase == deu_pkg::PH_CHAN || prs_phase == deu_pkg::PH_TRIG)
            begin
                case (word_in_triplet)
                    2'd0:
                    begin
                        v[0] = w[11:0];
                        v[1] = w[23:12];
                        held_bits = w[31:24];
                        cnt = 2;
                        base = 0;
                    end
                    2'd1:
                    begin
                        v[0] = {w[3:0], held_bits};
                        v[1] = w[15:4];
                        v[2] = w[27:16];
                        held_bits = {4'h0, w[31:28]};
                        cnt = 3;
                        base = 2;
                    end
                    default:
                    begin
                        v[0] = {w[7:0], held_bits[3:0]};
                        v[1] = w[19:8];
                        v[2] = w[31:20];
                        cnt = 3;
                        base = 5;
                    end
                endcase
            end
            case (prs_phase)
                deu_pkg::PH_MASK:
                begin
                    ev_mask = w[3:0] & deu_pkg::GROUP_BITS;
                    prs_phase = deu_pkg::PH_EVNR;
                end
                deu_pkg::PH_EVNR:
                begin
                    ev_number = w[21:0];
                    add_result(deu_pkg::KIND_EVENT_HDR, 3'd0, 10'd0, 12'd0, 10'd0);
                    prs_phase = deu_pkg::PH_SKIP;
                end
                deu_pkg::PH_SKIP, deu_pkg::PH_TRAIL:
                begin
                    g = first_group(ev_mask, (prs_phase == deu_pkg::PH_SKIP)
                                             ? 0 : int'(cur_group) + 1);
                    if (g >= deu_pkg::NUM_GROUPS)
                    begin
                        add_result(deu_pkg::KIND_EVENT_END, 3'd0, 10'd0, 12'd0, 10'd0);
                        prs_phase = deu_pkg::PH_WAIT;
                    end
                    else
                    begin
                        cur_group = g[1:0];
                        prs_phase = deu_pkg::PH_GHDR;
                    end
                end
                deu_pkg::PH_GHDR:
                begin
                    grp_trigger = w[12];
                    // Only the first present group sets the sample count.
                    if (!n_known)
                    begin
                        k = int'(w[11:0]) / 3;
                        if (k > deu_pkg::MAX_SAMPLES)
                        begin
                            k = deu_pkg::MAX_SAMPLES;
                        end
                        n_samples = k[10:0];
                        ev_freq = w[17:16];
                        n_known = 1'b1;
                    end
                    add_result(deu_pkg::KIND_GROUP_HDR, 3'd0, 10'd0, 12'd0, w[29:20]);
                    samp_pos = '0;
                    word_in_triplet = '0;
                    held_bits = '0;
                    prs_phase = (n_samples > 0) ? deu_pkg::PH_CHAN : deu_pkg::PH_TRAIL;
                end
                deu_pkg::PH_CHAN:
                begin
                    for (int i = 0; i < cnt; i++)
                    begin
                        add_result(deu_pkg::KIND_CHAN_SAMPLE, 3'(base + i),
                                   samp_pos[9:0], v[i], 10'd0);
                    end
                    if (word_in_triplet == 2'd2)
                    begin
                        word_in_triplet = '0;
                        samp_pos = samp_pos + 11'd1;
                        if (samp_pos >= n_samples)
                        begin
                            samp_pos = '0;
                            prs_phase = grp_trigger ? deu_pkg::PH_TRIG : deu_pkg::PH_TRAIL;
                        end
                    end
                    else
                    begin
                        word_in_triplet = word_in_triplet + 2'd1;
                    end
                end
                default:
                begin
                    // Trigger waveform: slots past the sample count are dropped.
                    for (int i = 0; i < cnt; i++)
                    begin
                        k = int'(samp_pos) + base + i;
                        if (k < int'(n_samples))
                        begin
                            add_result(deu_pkg::KIND_TRIG_SAMPLE, 3'd0, k[9:0], v[i],
                                       10'd0);
                        end
                    end
                    if (word_in_triplet == 2'd2)
                    begin
                        word_in_triplet = '0;
                        samp_pos = samp_pos + 11'd8;
                        if (samp_pos >= n_samples)
                        begin
                            samp_pos = '0;
                            prs_phase = deu_pkg::PH_TRAIL;
                        end
                    end
                    else
                    begin
                        word_in_triplet = word_in_triplet + 2'd1;
                    end
                end
            endcase
        end
        if (predicted_results.size() > n_before)
        begin
            predicted_results[predicted_results.size() - 1].last = 1'b1;
        end
    endtask

    // Compare one result field and report a difference.
    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            fail_count++;
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        end
    endtask

    task automatic push_word(input logic [31:0] data, input logic sof, input logic drain);
        stream_word_t s;
        s.data = data;
        s.sof = sof;
        s.drain_first = drain;
        word_stream.push_back(s);
        words_queued++;
    endtask

    // Queue one event; trig_mode 0 off, 1 on, 2 random per group.
    // A truncated event stops at a random word short of its end.
    task automatic queue_event(input logic [3:0] mask, input int count_field,
                               input int trig_mode, input logic sof,
                               input logic drain, input bit truncate);
        logic [31:0] ev [$];
        logic [31:0] w;
        int          ns;
        int          stop;
        bit          first;
        bit          trig;
        first = 1'b1;
        ns = count_field / 3;
        if (ns > deu_pkg::MAX_SAMPLES)
        begin
            ns = deu_pkg::MAX_SAMPLES;
        end
        ev.push_back({deu_pkg::HEADER_MARKER, 28'($urandom)});
        w = $urandom;
        w[3:0] = mask;
        ev.push_back(w);
        ev.push_back($urandom);
        ev.push_back($urandom);
        for (int g = 0; g < deu_pkg::NUM_GROUPS; g++)
        begin
            if (mask[g])
            begin
                w = $urandom;
                trig = (trig_mode == 2) ? 1'($urandom_range(0, 1)) : 1'(trig_mode);
                w[12] = trig;
                if (first)
                begin
                    w[11:0] = 12'(count_field);
                end
                first = 1'b0;
                ev.push_back(w);
                if (ns > 0)
                begin
                    repeat (3 * ns) ev.push_back($urandom);
                    if (trig)
                    begin
                        repeat (3 * ((ns + 7) / 8)) ev.push_back($urandom);
                    end
                end
                ev.push_back($urandom);
            end
        end
        stop = truncate ? $urandom_range(1, ev.size() - 1) : ev.size();
        for (int i = 0; i < stop; i++)
        begin
            push_word(ev[i], (i == 0) ? sof : 1'b0, (i == 0) ? drain : 1'b0);
        end
    endtask

    // Stimulus: directed cases, random events, then one event with the largest word count, cut short.
    initial
    begin : stimulus
        int          r;
        int          count_field;
        bit          resync;
        bit          paused;
        bit          drain_now;
        logic [31:0] hdr_word;
        resync = 1'b0;
        paused = 1'b0;
        clear_parser();

        // Stray words while waiting, both with a bad marker.
        push_word(32'h0000_0000, 1'b0, 1'b0);
        push_word(32'hffff_ffff, 1'b1, 1'b0);
        // Event with no groups ends on the skipped word.
        queue_event(4'b0000, 0, 0, 1'b0, 1'b0, 1'b0);
        // An event abandoned by a new start mark; the new one has no samples.
        push_word({deu_pkg::HEADER_MARKER, 28'h0ff_ffff}, 1'b0, 1'b0);
        push_word(32'h0000_000f, 1'b0, 1'b0);
        queue_event(4'b1000, 2, 1, 1'b1, 1'b0, 1'b0);
        // One sample with a trigger waveform, so two trigger words give nothing.
        queue_event(4'b0001, 3, 1, 1'b0, 1'b0, 1'b0);

        // Random events, mostly well formed, with truncation and noise.
        while (words_queued < 150)
        begin
            r = $urandom_range(0, 99);
            count_field = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 45)
                                                      : $urandom_range(0, 24);
            if (r < 70)
            begin
                drain_now = !paused && (words_queued >= 100);
                queue_event(4'($urandom_range(0, 15)), count_field, 2,
                            resync ? 1'b1 : 1'($urandom_range(0, 1)),
                            drain_now, 1'b0);
                if (drain_now)
                begin
                    paused = 1'b1;
                end
                resync = 1'b0;
            end
            else if (r < 85)
            begin
                queue_event(4'($urandom_range(0, 15)), count_field, 2,
                            resync ? 1'b1 : 1'($urandom_range(0, 1)), 1'b0, 1'b1);
                resync = 1'b1;
            end
            else
            begin
                repeat ($urandom_range(1, 3))
                begin
                    push_word($urandom, 1'($urandom_range(0, 1)), 1'b0);
                end
                resync = 1'b1;
            end
        end

        // Largest word count, clamped to the maximum sample count; the event
        // is cut short after a few sample words.
        push_word({deu_pkg::HEADER_MARKER, 28'($urandom)}, 1'b1, !paused);
        push_word(32'h0000_000f, 1'b0, 1'b0);
        push_word($urandom, 1'b0, 1'b0);
        push_word($urandom, 1'b0, 1'b0);
        hdr_word = $urandom;
        hdr_word[11:0] = 12'hfff;
        push_word(hdr_word, 1'b0, 1'b0);
        repeat (12) push_word($urandom, 1'b0, 1'b0);

        reset_wait: begin
            repeat (4) @(posedge clk);
            @(negedge clk);
            rst_n = 1'b1;
        end

        while (word_stream.size() > 0 || in_valid)
        begin
            @(negedge clk);
        end
        while (predicted_results.size() > 0)
        begin
            @(negedge clk);
        end
        repeat (20) @(negedge clk);
        if (fail_count == 0)
        begin
            $display("** digitizer_event_word_unpacker: PASSED **");
        end
        else
        begin
            $display("** digitizer_event_word_unpacker: FAILED **");
        end
        $finish;
    end

    // Word driver: offers the next queued word once the previous transfer is done.
    always @(negedge clk)
    begin : drive_words
        stream_word_t s;
        bit           offer;
        if (rst_n && (!in_valid || word_taken))
        begin
            offer = 1'b0;
            if (word_stream.size() > 0)
            begin
                if (word_stream[0].drain_first
                    && (predicted_results.size() > 0 || out_valid))
                begin
                    offer = 1'b0;
                end
                else
                begin
                    offer = calm || ($urandom_range(0, 99) >= 17);
                end
            end
            if (offer)
            begin
                s = word_stream.pop_front();
                word <= s.data;
                start_of_event <= s.sof;
                in_valid <= 1'b1;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Result receiver: random stalls and two long hold-offs.
    always @(negedge clk)
    begin : drive_ready
        if (rst_n)
        begin
            if (hold_left == 0 && holds_done < 2
                && words_accepted >= ((holds_done == 0) ? 40 : 130))
            begin
                hold_left = 80;
                holds_done++;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (calm)
            begin
                out_ready <= 1'b1;
            end
            else
            begin
                out_ready <= ($urandom_range(0, 99) >= 17);
            end
        end
    end

    // Monitor: predicts on each input transfer, checks each output transfer.
    always @(posedge clk)
    begin : monitor
        unpacked_result_t want;
        if (rst_n)
        begin
            cycle_count <= cycle_count + 1;
            word_taken <= in_valid && in_ready;
            if (in_valid && in_ready)
            begin
                decode_word(word, start_of_event);
                words_accepted <= words_accepted + 1;
            end
            if (out_valid && out_ready)
            begin
                if (predicted_results.size() == 0)
                begin
                    fail_count++;
                    $error("result with none expected: kind %0d", kind);
                end
                else
                begin
                    want = predicted_results.pop_front();
                    check_field("kind", want.kind, kind);
                    check_field("group", want.grp, group);
                    check_field("channel", want.chan, channel);
                    check_field("sample_index", want.sidx, sample_index);
                    check_field("value", want.val, value);
                    check_field("event_number", want.evnum, event_number);
                    check_field("payload_length", want.plen, payload_length);
                    check_field("enabled_groups", want.gmask, enabled_groups);
                    check_field("frequency", want.freq, frequency);
                    check_field("start_cell", want.icell, start_cell);
                    check_field("trigger_present", want.trig, trigger_present);
                    check_field("last", want.last, last);
                end
            end
            // Watchdog on cycles with no transfer on either side.
            if ((in_valid && in_ready) || (out_valid && out_ready))
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("** digitizer_event_word_unpacker: FAILED **");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

endmodule
